// ----- rtl/round_robin_quantum_scheduler_top_defines.svh -----
// ----------------------------------------------------------------------------
// round robin quantum scheduler assertion macros
// shared property templates for the scheduler assertions
// ----------------------------------------------------------------------------
`ifndef ROUND_ROBIN_QUANTUM_SCHEDULER_TOP_DEFINES_SVH
`define ROUND_ROBIN_QUANTUM_SCHEDULER_TOP_DEFINES_SVH

// same-cycle implication
`define RRQS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RRQS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/rrqs_pkg.sv -----
// ----------------------------------------------------------------------------
// rrqs_pkg
// types and codes shared by the scheduler controller, datapath and top level
// ----------------------------------------------------------------------------
`default_nettype none

package rrqs_pkg;

  localparam int ID_BITS = 6;
  localparam int ID_SPACE = 64;

  localparam logic [1:0] OP_TICK = 2'd0;
  localparam logic [1:0] OP_ADD  = 2'd1;
  localparam logic [1:0] OP_SET  = 2'd2;

  localparam logic [1:0] PST_READY   = 2'd0;
  localparam logic [1:0] PST_BLOCKED = 2'd1;
  localparam logic [1:0] PST_TERM    = 2'd2;

  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_FULL = 2'd1;
  localparam logic [1:0] STAT_IDLE = 2'd2;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [5:0]  proc_id;
    logic [7:0]  priority_req;
    logic [1:0]  proc_state;
    logic [63:0] context_value;
  } in_item_t;

  typedef struct packed {
    logic [5:0]  running_id;
    logic [63:0] context_out;
    logic [1:0]  status;
  } out_item_t;

  typedef struct packed {
    logic add;
    logic set_state;
    logic save_ctx;
    logic rd_cur_st;
    logic q_dec;
    logic push_cur;
    logic start_walk;
    logic pop;
    logic rd_id;
    logic push_id;
    logic sel_id;
    logic sel_idle;
    logic rd_ctx;
    logic load_tick;
    logic load_misc;
  } cmd_t;

  typedef struct packed {
    logic cur_valid;
    logic running_idle;
    logic keep_ok;
    logic id_ready;
    logic id_term;
    logic walk_done;
  } sts_t;

endpackage

`default_nettype wire

// ----- rtl/rrqs_dp.sv -----
// ----------------------------------------------------------------------------
// rrqs_dp
// scheduler datapath: ready ring, per-process tables, running process state
// ----------------------------------------------------------------------------
`default_nettype none

module rrqs_dp #(
  parameter int MAX_PROCS     = 64,
  parameter int CONTEXT_BITS  = 64,
  parameter int PRIORITY_BITS = 8
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_wr,
  input  wire logic [5:0]          cfg_data,
  input  wire rrqs_pkg::in_item_t  in_data,
  input  wire rrqs_pkg::cmd_t      cmd,
  output rrqs_pkg::sts_t           sts,
  output rrqs_pkg::out_item_t      out_data
);
  import rrqs_pkg::*;

  localparam int RW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int CW = $clog2(MAX_PROCS + 1);

  logic [ID_BITS-1:0]       ring_mem [MAX_PROCS];
  logic [1:0]               st_mem   [ID_SPACE];
  logic [PRIORITY_BITS-1:0] pr_mem   [ID_SPACE];
  logic [CONTEXT_BITS-1:0]  cx_mem   [ID_SPACE];

  logic [ID_SPACE-1:0]      st_vld_r;
  logic [1:0]               st_rd_r;
  logic                     st_vld_rd_r;
  logic [PRIORITY_BITS-1:0] pr_rd_r;
  logic [CONTEXT_BITS-1:0]  cx_rd_r;
  logic [ID_BITS-1:0]       ring_rd_r;
  logic [ID_BITS-1:0]       id_r;

  logic [5:0]               idle_id_r;
  logic [RW-1:0]            head_r, tail_r;
  logic [CW-1:0]            count_r, count_nxt;
  logic [CW-1:0]            walk_n_r, walk_i_r;
  logic [ID_BITS-1:0]       cur_id_r;
  logic                     cur_valid_r;
  logic                     running_idle_r;
  logic [PRIORITY_BITS-1:0] q_r;
  out_item_t                out_r;

  logic                     ring_full, push_req, push_ok;
  logic [ID_BITS-1:0]       push_data;
  logic [1:0]               st_eff;
  logic [ID_BITS-1:0]       st_rd_addr;
  logic                     st_wr;
  logic [1:0]               st_wr_data;
  logic                     cx_wr;
  logic [ID_BITS-1:0]       cx_wr_addr;
  logic [CONTEXT_BITS-1:0]  cx_wr_data;

  assign ring_full = (count_r == CW'(MAX_PROCS));
  assign push_req  = cmd.add | cmd.push_cur | cmd.push_id;
  assign push_ok   = push_req & ~ring_full;
  assign push_data = cmd.add ? in_data.proc_id : (cmd.push_cur ? cur_id_r : id_r);
  assign count_nxt = count_r + CW'(push_ok) - CW'(cmd.pop);

  // never-written status entries read as terminated
  assign st_eff     = st_vld_rd_r ? st_rd_r : PST_TERM;
  assign st_rd_addr = cmd.rd_cur_st ? cur_id_r : ring_rd_r;

  assign st_wr      = (cmd.add & push_ok) |
                      (cmd.set_state & (in_data.proc_state != 2'd3));
  assign st_wr_data = cmd.add ? PST_READY : in_data.proc_state;

  assign cx_wr      = (cmd.add & push_ok) | (cmd.save_ctx & cur_valid_r);
  assign cx_wr_addr = cmd.add ? in_data.proc_id : cur_id_r;
  assign cx_wr_data = in_data.context_value[CONTEXT_BITS-1:0];

  // memories
  always_ff @(posedge clk) begin
    if (push_ok) begin
      ring_mem[tail_r] <= push_data;
    end
    if (cmd.pop) begin
      ring_rd_r <= ring_mem[head_r];
    end
    if (st_wr) begin
      st_mem[in_data.proc_id] <= st_wr_data;
    end
    if (cmd.rd_cur_st | cmd.rd_id) begin
      st_rd_r     <= st_mem[st_rd_addr];
      st_vld_rd_r <= st_vld_r[st_rd_addr];
    end
    if (cmd.add & push_ok) begin
      pr_mem[in_data.proc_id] <= in_data.priority_req[PRIORITY_BITS-1:0];
    end
    if (cmd.rd_id) begin
      pr_rd_r <= pr_mem[ring_rd_r];
      id_r    <= ring_rd_r;
    end
    if (cx_wr) begin
      cx_mem[cx_wr_addr] <= cx_wr_data;
    end
    if (cmd.rd_ctx) begin
      cx_rd_r <= cx_mem[cur_id_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_vld_r       <= '0;
      idle_id_r      <= '0;
      head_r         <= '0;
      tail_r         <= '0;
      count_r        <= '0;
      walk_n_r       <= '0;
      walk_i_r       <= '0;
      cur_id_r       <= '0;
      cur_valid_r    <= 1'b0;
      running_idle_r <= 1'b0;
      q_r            <= '0;
    end else begin
      if (st_wr) begin
        st_vld_r[in_data.proc_id] <= 1'b1;
      end
      if (cfg_wr) begin
        idle_id_r <= cfg_data;
      end
      if (push_ok) begin
        tail_r <= (tail_r == RW'(MAX_PROCS - 1)) ? '0 : tail_r + RW'(1);
      end
      if (cmd.pop) begin
        head_r   <= (head_r == RW'(MAX_PROCS - 1)) ? '0 : head_r + RW'(1);
        walk_i_r <= walk_i_r + CW'(1);
      end
      count_r <= count_nxt;
      if (cmd.start_walk) begin
        walk_n_r <= count_nxt;
        walk_i_r <= '0;
      end
      if (cmd.q_dec) begin
        q_r <= q_r - PRIORITY_BITS'(1);
      end
      if (cmd.sel_id) begin
        cur_id_r       <= id_r;
        cur_valid_r    <= 1'b1;
        running_idle_r <= 1'b0;
        q_r            <= pr_rd_r;
      end else if (cmd.sel_idle) begin
        cur_id_r       <= idle_id_r;
        cur_valid_r    <= 1'b1;
        running_idle_r <= 1'b1;
        q_r            <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_tick) begin
      out_r.running_id  <= cur_id_r;
      out_r.context_out <= 64'(cx_rd_r);
      out_r.status      <= running_idle_r ? STAT_IDLE : STAT_OK;
    end else if (cmd.load_misc) begin
      out_r.running_id  <= cur_valid_r ? cur_id_r : idle_id_r;
      out_r.context_out <= '0;
      out_r.status      <= (cmd.add & ~push_ok) ? STAT_FULL : STAT_OK;
    end
  end

  assign out_data = out_r;

  always_comb begin
    sts.cur_valid    = cur_valid_r;
    sts.running_idle = running_idle_r;
    sts.keep_ok      = cur_valid_r & ~running_idle_r & (q_r != '0) & (st_eff == PST_READY);
    sts.id_ready     = (st_eff == PST_READY);
    sts.id_term      = (st_eff == PST_TERM);
    sts.walk_done    = (walk_i_r == walk_n_r);
  end

endmodule

`default_nettype wire

// ----- rtl/rrqs_ctrl.sv -----
// ----------------------------------------------------------------------------
// rrqs_ctrl
// scheduler controller: sequences item handling and the ring walk
// ----------------------------------------------------------------------------
`default_nettype none

module rrqs_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire logic [1:0]      in_opcode,
  output logic                 out_valid,
  input  wire logic            out_ready,
  input  wire rrqs_pkg::sts_t  sts,
  output rrqs_pkg::cmd_t       cmd
);
  import rrqs_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_T1   = 3'd1;
  localparam logic [2:0] S_POP  = 3'd2;
  localparam logic [2:0] S_ID   = 3'd3;
  localparam logic [2:0] S_CHK  = 3'd4;
  localparam logic [2:0] S_CTX  = 3'd5;
  localparam logic [2:0] S_CTXW = 3'd6;
  localparam logic [2:0] S_OUT  = 3'd7;

  logic [2:0] state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_OUT;
          case (in_opcode)
            OP_TICK: begin
              cmd.save_ctx  = 1'b1;
              cmd.rd_cur_st = 1'b1;
              state_nxt     = S_T1;
            end
            OP_ADD: begin
              cmd.add       = 1'b1;
              cmd.load_misc = 1'b1;
            end
            OP_SET: begin
              cmd.set_state = 1'b1;
              cmd.load_misc = 1'b1;
            end
            default: begin
              cmd.load_misc = 1'b1;
            end
          endcase
        end
      end
      S_T1: begin
        if (sts.keep_ok) begin
          cmd.q_dec  = 1'b1;
          cmd.rd_ctx = 1'b1;
          state_nxt  = S_CTXW;
        end else begin
          cmd.push_cur   = sts.cur_valid & ~sts.running_idle;
          cmd.start_walk = 1'b1;
          state_nxt      = S_POP;
        end
      end
      S_POP: begin
        if (sts.walk_done) begin
          cmd.sel_idle = 1'b1;
          state_nxt    = S_CTX;
        end else begin
          cmd.pop   = 1'b1;
          state_nxt = S_ID;
        end
      end
      S_ID: begin
        cmd.rd_id = 1'b1;
        state_nxt = S_CHK;
      end
      S_CHK: begin
        if (sts.id_ready) begin
          cmd.sel_id = 1'b1;
          state_nxt  = S_CTX;
        end else begin
          // blocked entries go back in the ring, terminated ones drop out
          cmd.push_id = ~sts.id_term;
          if (sts.walk_done) begin
            cmd.sel_idle = 1'b1;
            state_nxt    = S_CTX;
          end else begin
            cmd.pop   = 1'b1;
            state_nxt = S_ID;
          end
        end
      end
      S_CTX: begin
        cmd.rd_ctx = 1'b1;
        state_nxt  = S_CTXW;
      end
      S_CTXW: begin
        cmd.load_tick = 1'b1;
        state_nxt     = S_OUT;
      end
      S_OUT: begin
        if (out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/round_robin_quantum_scheduler_top.sv -----
// ----------------------------------------------------------------------------
// round_robin_quantum_scheduler_top
// round robin process scheduler with a per-process quantum
// ----------------------------------------------------------------------------
// usage:
//   in_valid/in_ready/in_data carry one item: tick, add process or set state.
//   out_valid/out_ready/out_data return exactly one result per item.
//   cfg_valid/cfg_ready/cfg_data write the idle process id; cfg_ready is
//   always high, write only while no item is in flight.
// item handling:
//   one item is handled at a time; in_ready is low until its result transfers.
//   add, set-state and no-op: result valid in the cycle after the input transfer.
//   tick that keeps the running process: result after states T1 and CTXW.
//   tick that reschedules: states T1 and POP, then ID and CHK for each
//   entry visited in the walk over the ready ring memory (up to 64
//   entries), then CTX and CTXW.
// reset: ring empty, every process terminated, nothing running, idle id 0.
// stall: the result holds in the output register while out_ready is low and
//   no new item is taken until it transfers.
`default_nettype none
`include "round_robin_quantum_scheduler_top_defines.svh"

module round_robin_quantum_scheduler_top #(
  parameter int MAX_PROCS     = 64,
  parameter int CONTEXT_BITS  = 64,
  parameter int PRIORITY_BITS = 8
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [5:0]           cfg_data,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire rrqs_pkg::in_item_t   in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output rrqs_pkg::out_item_t       out_data
);
  import rrqs_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  rrqs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_opcode (in_data.opcode),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  rrqs_dp #(
    .MAX_PROCS     (MAX_PROCS),
    .CONTEXT_BITS  (CONTEXT_BITS),
    .PRIORITY_BITS (PRIORITY_BITS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_wr   (cfg_valid & cfg_ready),
    .cfg_data (cfg_data),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

  `RRQS_ASSERT_SAME(a_no_accept_with_result, out_valid, !in_ready, "input taken while result pending")
  `RRQS_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "controller not busy after transfer")
  `RRQS_ASSERT_SAME(a_idle_status_match, out_valid && out_data.status == STAT_IDLE, sts.running_idle, "idle status without idle process")

endmodule

`default_nettype wire

// ----- tb/sv/round_robin_quantum_scheduler_top_test.sv -----
// ----------------------------------------------------------------------------
// round_robin_quantum_scheduler_top_test
// drives ticks, process adds and state changes with random gaps on both
// channels, predicts each result from a behavioral scheduler and compares
// ----------------------------------------------------------------------------
`default_nettype none

module round_robin_quantum_scheduler_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import rrqs_pkg::*;

  logic clk;
  logic rst_n;
  logic cfg_valid;
  logic cfg_ready;
  logic [5:0] cfg_data;
  logic in_valid;
  logic in_ready;
  in_item_t in_data;
  logic out_valid;
  logic out_ready;
  out_item_t out_data;

  round_robin_quantum_scheduler_top u_top (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  // scheduler shadow state
  logic [5:0]  sch_idle_id;
  logic [5:0]  sch_ring [64];
  logic [5:0]  sch_head;
  logic [5:0]  sch_tail;
  int          sch_count;
  logic [1:0]  sch_pstate [64];
  logic [7:0]  sch_prio [64];
  logic [63:0] sch_ctx [64];
  logic [5:0]  sch_cur;
  logic        sch_cur_valid;
  logic [7:0]  sch_quantum;
  logic        sch_idle_run;

  in_item_t  pending_items[$];
  out_item_t expected_results[$];
  int mismatches;
  bit sending_done;

  // input transfer seen at the last rising edge
  logic in_taken;

  function automatic bit ring_push(logic [5:0] id);
    if (sch_count >= 64) return 0;
    sch_ring[sch_tail] = id;
    sch_tail = 6'(sch_tail + 6'd1);
    sch_count++;
    return 1;
  endfunction

  function automatic logic [5:0] ring_pop();
    logic [5:0] id;
    id = sch_ring[sch_head];
    sch_head = 6'(sch_head + 6'd1);
    sch_count--;
    return id;
  endfunction

  function automatic void schedule_tick(logic [63:0] ctx);
    int n;
    logic [5:0] id;
    bit ok;
    if (sch_cur_valid) sch_ctx[sch_cur] = ctx;
    if (sch_cur_valid && !sch_idle_run && sch_quantum != 0 &&
        sch_pstate[sch_cur] == PST_READY) begin
      sch_quantum--;
      return;
    end
    if (sch_cur_valid && !sch_idle_run) ok = ring_push(sch_cur);
    n = sch_count;
    for (int i = 0; i < n; i++) begin
      id = ring_pop();
      if (sch_pstate[id] == PST_READY) begin
        sch_cur = id;
        sch_cur_valid = 1;
        sch_idle_run = 0;
        sch_quantum = sch_prio[id];
        return;
      end
      if (sch_pstate[id] != PST_TERM) ok = ring_push(id);
    end
    sch_cur = sch_idle_id;
    sch_cur_valid = 1;
    sch_idle_run = 1;
    sch_quantum = 0;
  endfunction

  function automatic out_item_t schedule_item(in_item_t it);
    out_item_t r;
    r.context_out = '0;
    r.status = STAT_OK;
    case (it.opcode)
      OP_TICK: begin
        schedule_tick(it.context_value);
        r.context_out = sch_ctx[sch_cur];
        if (sch_idle_run) r.status = STAT_IDLE;
      end
      OP_ADD: begin
        if (ring_push(it.proc_id)) begin
          sch_prio[it.proc_id] = it.priority_req;
          sch_ctx[it.proc_id] = it.context_value;
          sch_pstate[it.proc_id] = PST_READY;
        end else begin
          r.status = STAT_FULL;
        end
      end
      OP_SET: begin
        if (it.proc_state <= PST_TERM) sch_pstate[it.proc_id] = it.proc_state;
      end
      default: ;
    endcase
    r.running_id = sch_cur_valid ? sch_cur : sch_idle_id;
    return r;
  endfunction

  function automatic int gap_len();
    if ($urandom_range(0, 2) == 0) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    return $urandom_range(0, 3);
  endfunction

  function automatic in_item_t make_item(logic [1:0] op, logic [5:0] id,
                                         logic [7:0] prio, logic [1:0] st,
                                         logic [63:0] ctx);
    in_item_t it;
    it.opcode = op;
    it.proc_id = id;
    it.priority_req = prio;
    it.proc_state = st;
    it.context_value = ctx;
    return it;
  endfunction

  function automatic logic [63:0] rand_ctx();
    return {$urandom(), $urandom()};
  endfunction

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // driver: one transfer per accepted item, random gaps between items
  int drv_gap;
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 0;
      drv_gap = 0;
    end else if (in_valid && !in_taken) begin
      // hold
    end else if (in_valid && in_taken) begin
      // transfer happened on the last rising edge
      drv_gap = gap_len();
      if (drv_gap == 0 && pending_items.size() > 0) begin
        in_data <= pending_items.pop_front();
      end else begin
        in_valid <= 0;
      end
    end else if (drv_gap > 0) begin
      drv_gap--;
    end else if (pending_items.size() > 0) begin
      in_data <= pending_items.pop_front();
      in_valid <= 1;
    end
  end

  // predict on input transfer, check on output transfer
  always @(posedge clk) begin
    in_taken <= rst_n && in_valid && in_ready;
    if (rst_n && in_valid && in_ready)
      expected_results.push_back(schedule_item(in_data));
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", out_data);
      end else begin
        out_item_t e;
        e = expected_results.pop_front();
        if (e.running_id !== out_data.running_id || e.context_out !== out_data.context_out ||
            e.status !== out_data.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected id %0d ctx %h st %0d, got id %0d ctx %h st %0d",
                     e.running_id, e.context_out, e.status,
                     out_data.running_id, out_data.context_out, out_data.status);
        end
      end
    end
  end

  // receiver stalls
  int rcv_gap;
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 0;
      rcv_gap = 0;
    end else if (rcv_gap > 0) begin
      rcv_gap--;
      out_ready <= 0;
    end else begin
      out_ready <= 1;
      rcv_gap = gap_len();
    end
  end

  task automatic wait_drained();
    while (pending_items.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  task automatic write_idle(logic [5:0] v);
    @(negedge clk);
    cfg_data <= v;
    cfg_valid <= 1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sch_idle_id = v;
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  // one phase of random traffic; ids kept in a smaller pool most of the time
  task automatic random_phase(int n_items);
    int r;
    logic [5:0] id;
    for (int k = 0; k < n_items; k++) begin
      r = $urandom_range(0, 99);
      id = ($urandom_range(0, 3) == 0) ? 6'($urandom()) : 6'($urandom_range(0, 11));
      if (r < 40)
        pending_items.push_back(make_item(OP_TICK, 6'($urandom()), 8'($urandom()),
                                          2'($urandom()), rand_ctx()));
      else if (r < 65)
        pending_items.push_back(make_item(OP_ADD, id,
                                          ($urandom_range(0, 3) == 0) ? 8'($urandom())
                                                                      : 8'($urandom_range(0, 3)),
                                          2'($urandom()), rand_ctx()));
      else if (r < 95)
        pending_items.push_back(make_item(OP_SET, id, 8'($urandom()),
                                          2'($urandom_range(0, 3)), rand_ctx()));
      else
        pending_items.push_back(make_item(2'd3, id, 8'($urandom()), 2'($urandom()),
                                          rand_ctx()));
    end
  endtask

  initial begin
    mismatches = 0;
    sending_done = 0;
    rst_n = 0;
    cfg_valid = 0;
    cfg_data = '0;
    in_valid = 0;
    in_data = '0;
    out_ready = 0;
    sch_idle_id = 0;
    sch_head = 0;
    sch_tail = 0;
    sch_count = 0;
    sch_cur = 0;
    sch_cur_valid = 0;
    sch_quantum = 0;
    sch_idle_run = 0;
    for (int i = 0; i < 64; i++) begin
      sch_pstate[i] = PST_TERM;
      sch_prio[i] = '0;
      sch_ctx[i] = '0;
      sch_ring[i] = '0;
    end
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // idle id 63; add it first so its context is written before idle runs
    write_idle(6'd63);
    pending_items.push_back(make_item(OP_ADD, 6'd63, 8'd0, PST_READY, '1));
    pending_items.push_back(make_item(OP_ADD, 6'd0, 8'd255, PST_READY, '0));
    pending_items.push_back(make_item(OP_ADD, 6'd5, 8'd1, PST_READY, 64'h0123456789abcdef));
    pending_items.push_back(make_item(OP_TICK, 6'd0, 8'd0, PST_READY, 64'hdead_beef));
    pending_items.push_back(make_item(OP_TICK, 6'd0, 8'd0, PST_READY, 64'h1));
    pending_items.push_back(make_item(OP_SET, 6'd0, 8'd0, PST_BLOCKED, '0));
    pending_items.push_back(make_item(OP_TICK, 6'd0, 8'd0, PST_READY, 64'h2));
    pending_items.push_back(make_item(OP_SET, 6'd5, 8'd0, PST_TERM, '0));
    pending_items.push_back(make_item(OP_SET, 6'd63, 8'd0, PST_TERM, '0));
    pending_items.push_back(make_item(OP_TICK, 6'd0, 8'd0, PST_READY, 64'h3));
    pending_items.push_back(make_item(OP_TICK, 6'd0, 8'd0, PST_READY, 64'h4));
    pending_items.push_back(make_item(OP_SET, 6'd40, 8'd0, PST_READY, '0));
    pending_items.push_back(make_item(OP_SET, 6'd0, 8'd0, 2'd3, '0));
    pending_items.push_back(make_item(2'd3, 6'd0, 8'd0, PST_READY, '1));
    pending_items.push_back(make_item(OP_ADD, 6'd5, 8'd2, PST_READY, 64'h55));
    pending_items.push_back(make_item(OP_SET, 6'd0, 8'd0, PST_READY, '0));
    pending_items.push_back(make_item(OP_TICK, 6'd0, 8'd0, PST_READY, 64'h6));
    // fill the ring to reach the full case and requeue into a full ring
    for (int i = 0; i < 66; i++)
      pending_items.push_back(make_item(OP_ADD, 6'(i), 8'($urandom_range(0, 2)),
                                        PST_READY, rand_ctx()));
    pending_items.push_back(make_item(OP_TICK, 6'd0, 8'd0, PST_READY, rand_ctx()));
    pending_items.push_back(make_item(OP_TICK, 6'd0, 8'd0, PST_READY, rand_ctx()));
    wait_drained();

    // idle id 0 and others: each one already has a written context
    write_idle(6'd0);
    random_phase(150);
    wait_drained();
    write_idle(6'd5);
    random_phase(150);
    wait_drained();
    write_idle(6'd63);
    random_phase(100);
    wait_drained();

    if (mismatches == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  initial begin
    #20ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule

`default_nettype wire

// ----- round_robin_quantum_scheduler_top.f -----
+incdir+rtl
rtl/rrqs_pkg.sv
rtl/rrqs_dp.sv
rtl/rrqs_ctrl.sv
rtl/round_robin_quantum_scheduler_top.sv
tb/sv/round_robin_quantum_scheduler_top_test.sv
